@@ design/rge_pkg.sv @@
// shared types and constants for the graph reachability engine
`default_nettype none

package rge_pkg;

    // width of a page index field on the input stream
    localparam int PAGE_W = 6;

    // default number of pages kept in the graph
    localparam int NODES_DEF = 64;

    // stream data widths (whole bytes)
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;

    // action codes carried in the input item
    typedef enum logic [1:0] {
        ACT_ADD_PAGE = 2'd0,
        ACT_ADD_LINK = 2'd1,
        ACT_QUERY    = 2'd2
    } t_action;

    // status codes carried in the result item
    typedef enum logic [1:0] {
        ST_OK             = 2'd0,
        ST_PAGE_EXISTS    = 2'd1,
        ST_FIRST_MISSING  = 2'd2,
        ST_SECOND_MISSING = 2'd3
    } t_status;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LINK,
        S_PICK,
        S_EXPAND,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

@@ design/rge_ram.sv @@
// generic single-write, single-read ram with registered read data
`default_nettype none

module rge_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ design/rge_first_set.sv @@
// find-first-set unit: lowest set bit of a page vector
`default_nettype none

module rge_first_set #(
    parameter int WIDTH = 64
) (
    input  wire logic [WIDTH-1:0]         i_vec,
    output logic                          o_any,
    output logic      [$clog2(WIDTH)-1:0] o_index
);

    localparam int IDX_W = $clog2(WIDTH);

    // priority pick, lowest index wins
    always_comb begin
        o_index = '0;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            if (i_vec[i]) begin
                o_index = IDX_W'(i);
            end
        end
        o_any = |i_vec;
    end

endmodule

`default_nettype wire

@@ design/graph_reachability_engine.sv @@
// top level: page bitmap, adjacency ram and reachability sequencer
//
// Input stream (s side) carries one command per transaction: add a page,
// add a link from the first page to the second, or ask whether the second
// page can be reached from the first. Output stream (m side) returns one
// result per command: status, reachable answer and the sticky error flag.
// Pages with index at or above min(NODES, 64) are treated as missing.
// Add page, unused actions and rejected commands go straight from idle to
// the done state; an accepted add link passes a link state for the
// read-modify-write of the source row; an accepted query alternates pick
// and expand states until the answer is known, each page expanded at most
// once. Each expansion reads one adjacency row from the ram and merges it
// into the visited set in the next cycle; a find-first-set unit picks
// the next pending page. s_axis_tready is high only when the
// sequencer is idle. A finished result waits in the output register while
// the next command is accepted; if the receiver stalls, the sequencer holds
// the following result until the register frees up.
// Reset (synchronous, active low) empties the graph, row valid bits and
// the sticky error flag, and drops the output valid; no clearing pass.
`default_nettype none

module graph_reachability_engine #(
    parameter int NODES = rge_pkg::NODES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // [1:0] action, [7:2] first_page, [13:8] second_page, [15:14] zero
    input  wire logic [rge_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [1:0] status, [2] reachable, [3] error_seen, [7:4] zero
    output logic      [rge_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready
);

    localparam int PAGES = (NODES < (1 << rge_pkg::PAGE_W)) ? NODES
                                                            : (1 << rge_pkg::PAGE_W);
    localparam int IW    = $clog2(PAGES);
    localparam logic [rge_pkg::PAGE_W:0] PAGES_V = (rge_pkg::PAGE_W + 1)'(PAGES);

    // control state
    rge_pkg::t_state  r_state, n_state;
    logic [PAGES-1:0] r_present, n_present;
    logic [PAGES-1:0] r_row_valid, n_row_valid;
    logic             r_rd_valid, n_rd_valid;
    logic             r_out_valid, n_out_valid;
    logic             r_err, n_err;

    // working registers
    logic [PAGES-1:0] r_visit, n_visit;
    logic [PAGES-1:0] r_pend, n_pend;
    logic [IW-1:0]    r_src, n_src;
    logic [IW-1:0]    r_target, n_target;
    rge_pkg::t_status r_status, n_status;
    logic             r_reach, n_reach;
    rge_pkg::t_status r_out_status, n_out_status;
    logic             r_out_reach, n_out_reach;
    logic             r_out_err, n_out_err;

    // ram and pick unit connections
    logic             ram_wr_en;
    logic [IW-1:0]    ram_wr_addr;
    logic [PAGES-1:0] ram_wr_data;
    logic             ram_rd_en;
    logic [IW-1:0]    ram_rd_addr;
    logic [PAGES-1:0] ram_rd_data;
    logic             pick_any;
    logic [IW-1:0]    pick_idx;

    // input field decode
    rge_pkg::t_action           in_action;
    logic [rge_pkg::PAGE_W-1:0] in_first;
    logic [rge_pkg::PAGE_W-1:0] in_second;
    logic                       first_in_range;
    logic                       second_in_range;
    logic                       first_ok;
    logic                       second_ok;
    logic                       in_accept;
    logic [PAGES-1:0]           row_now;
    logic [PAGES-1:0]           new_bits;

    assign in_action = rge_pkg::t_action'(s_axis_tdata[1:0]);
    assign in_first  = s_axis_tdata[2 +: rge_pkg::PAGE_W];
    assign in_second = s_axis_tdata[2 + rge_pkg::PAGE_W +: rge_pkg::PAGE_W];

    assign first_in_range  = ({1'b0, in_first} < PAGES_V);
    assign second_in_range = ({1'b0, in_second} < PAGES_V);
    assign first_ok        = first_in_range && r_present[in_first[IW-1:0]];
    assign second_ok       = second_in_range && r_present[in_second[IW-1:0]];

    assign s_axis_tready = (r_state == rge_pkg::S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // adjacency row as read, a row never written reads as empty
    assign row_now  = r_rd_valid ? ram_rd_data : '0;
    assign new_bits = row_now & ~r_visit;

    // adjacency matrix, one row per source page
    rge_ram #(
        .WIDTH (PAGES),
        .DEPTH (PAGES)
    ) u_adj_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // next pending page to expand
    rge_first_set #(
        .WIDTH (PAGES)
    ) u_pick (
        .i_vec   (r_pend),
        .o_any   (pick_any),
        .o_index (pick_idx)
    );

    // sequencer: next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_present    = r_present;
        n_row_valid  = r_row_valid;
        n_out_valid  = r_out_valid;
        n_err        = r_err;
        n_visit      = r_visit;
        n_pend       = r_pend;
        n_src        = r_src;
        n_target     = r_target;
        n_status     = r_status;
        n_reach      = r_reach;
        n_out_status = r_out_status;
        n_out_reach  = r_out_reach;
        n_out_err    = r_out_err;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_src;
        ram_wr_data  = row_now | (PAGES'(1) << r_target);
        ram_rd_en    = 1'b0;
        ram_rd_addr  = in_first[IW-1:0];

        // result taken by the receiver
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            rge_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_status = rge_pkg::ST_OK;
                    n_reach  = 1'b0;
                    n_src    = in_first[IW-1:0];
                    n_target = in_second[IW-1:0];
                    n_state  = rge_pkg::S_DONE;
                    unique case (in_action)
                        rge_pkg::ACT_ADD_PAGE: begin
                            if (!first_in_range) begin
                                n_status = rge_pkg::ST_FIRST_MISSING;
                            end else if (r_present[in_first[IW-1:0]]) begin
                                n_status = rge_pkg::ST_PAGE_EXISTS;
                            end else begin
                                n_present[in_first[IW-1:0]] = 1'b1;
                            end
                        end
                        rge_pkg::ACT_ADD_LINK: begin
                            if (!first_ok) begin
                                n_status = rge_pkg::ST_FIRST_MISSING;
                            end else if (!second_ok) begin
                                n_status = rge_pkg::ST_SECOND_MISSING;
                            end else begin
                                ram_rd_en = 1'b1;
                                n_state   = rge_pkg::S_LINK;
                            end
                        end
                        rge_pkg::ACT_QUERY: begin
                            if (!first_ok) begin
                                n_status = rge_pkg::ST_FIRST_MISSING;
                            end else if (!second_ok) begin
                                n_status = rge_pkg::ST_SECOND_MISSING;
                            end else begin
                                n_visit = PAGES'(1) << in_first[IW-1:0];
                                n_pend  = PAGES'(1) << in_first[IW-1:0];
                                n_state = rge_pkg::S_PICK;
                            end
                        end
                        default: begin
                            // unused action: plain ok result
                        end
                    endcase
                end
            end
            rge_pkg::S_LINK: begin
                // read-modify-write of the source row
                ram_wr_en          = 1'b1;
                n_row_valid[r_src] = 1'b1;
                n_state            = rge_pkg::S_DONE;
            end
            rge_pkg::S_PICK: begin
                if (r_visit[r_target]) begin
                    n_reach = 1'b1;
                    n_visit = '0;
                    n_pend  = '0;
                    n_state = rge_pkg::S_DONE;
                end else if (!pick_any) begin
                    n_visit = '0;
                    n_state = rge_pkg::S_DONE;
                end else begin
                    ram_rd_en        = 1'b1;
                    ram_rd_addr      = pick_idx;
                    n_pend[pick_idx] = 1'b0;
                    n_state          = rge_pkg::S_EXPAND;
                end
            end
            rge_pkg::S_EXPAND: begin
                // merge successors not seen before
                n_visit = r_visit | new_bits;
                n_pend  = r_pend | new_bits;
                n_state = rge_pkg::S_PICK;
            end
            rge_pkg::S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_err        = r_err || (r_status != rge_pkg::ST_OK);
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_reach  = r_reach;
                    n_out_err    = r_err || (r_status != rge_pkg::ST_OK);
                    n_state      = rge_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rge_pkg::S_IDLE;
            end
        endcase

        // row valid bit follows the ram read
        n_rd_valid = ram_rd_en ? r_row_valid[ram_rd_addr] : r_rd_valid;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rge_pkg::S_IDLE;
            r_present   <= '0;
            r_row_valid <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_err       <= 1'b0;
            r_visit     <= '0;
            r_pend      <= '0;
        end else begin
            r_state     <= n_state;
            r_present   <= n_present;
            r_row_valid <= n_row_valid;
            r_rd_valid  <= n_rd_valid;
            r_out_valid <= n_out_valid;
            r_err       <= n_err;
            r_visit     <= n_visit;
            r_pend      <= n_pend;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_src        <= n_src;
        r_target     <= n_target;
        r_status     <= n_status;
        r_reach      <= n_reach;
        r_out_status <= n_out_status;
        r_out_reach  <= n_out_reach;
        r_out_err    <= n_out_err;
    end

    // output stream
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_err, r_out_reach, r_out_status};

endmodule

`default_nettype wire

@@ tb/tb_graph_reachability_engine.sv @@
// testbench for the graph reachability engine: directed and random command streams

module tb_graph_reachability_engine;
    timeunit 1ns;
    timeprecision 1ps;

    // action code the block leaves unused
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int PAGES = rge_pkg::NODES_DEF;
    localparam int PAGE_W = rge_pkg::PAGE_W;
    localparam int DRAIN_CYCLES = 200;

    // one command as packed into s_axis_tdata, action in the lowest bits
    typedef struct packed {
        logic [PAGE_W-1:0] second_page;
        logic [PAGE_W-1:0] first_page;
        logic [1:0]        action;
    } t_command;

    typedef struct {
        rge_pkg::t_status status;
        logic             reachable;
        logic             error_seen;
    } t_outcome;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    // [1:0] action, [7:2] first_page, [13:8] second_page, [15:14] zero
    logic [rge_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    // [1:0] status, [2] reachable, [3] error_seen, [7:4] zero
    logic [rge_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;

    graph_reachability_engine #(.NODES(PAGES)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    // shadow copy of the graph
    logic [PAGES-1:0] shadow_pages;
    logic [PAGES-1:0] shadow_links [PAGES];
    logic             shadow_sticky;

    t_outcome pending_results [$];

    bit tx_gaps_on;
    bit rx_stalls_on;
    int fail_count;
    int sent_count;
    int checked_count;
    int reached_count;
    int unreached_count;
    int error_count;
    int deepest_walk;

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #3_000_000;
        $display("timeout at %0t with %0d results outstanding", $time, pending_results.size());
        $display("Regression FAIL");
        $finish;
    end

    // gap length: mostly short, now and then long
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(30, 60);
    endfunction

    // round by round walk from one page, true once the target is visited
    function automatic bit walk_reaches(int from, int to);
        logic [PAGES-1:0] seen;
        logic [PAGES-1:0] front;
        logic [PAGES-1:0] grown;
        int rounds;
        seen = '0;
        seen[from] = 1'b1;
        front = seen;
        rounds = 0;
        forever begin
            if (seen[to]) begin
                if (rounds > deepest_walk) deepest_walk = rounds;
                return 1'b1;
            end
            grown = '0;
            for (int i = 0; i < PAGES; i++) begin
                if (front[i]) grown |= shadow_links[i];
            end
            grown &= ~seen;
            if (grown == '0) begin
                if (rounds > deepest_walk) deepest_walk = rounds;
                return 1'b0;
            end
            seen |= grown;
            front = grown;
            rounds++;
        end
    endfunction

    // apply one command to the shadow graph and give the result it causes
    function automatic t_outcome apply_command(t_command c);
        t_outcome o;
        int a;
        int b;
        a = int'(c.first_page);
        b = int'(c.second_page);
        o.status = rge_pkg::ST_OK;
        o.reachable = 1'b0;
        if (c.action == rge_pkg::ACT_ADD_PAGE) begin
            if (shadow_pages[a]) o.status = rge_pkg::ST_PAGE_EXISTS;
            else shadow_pages[a] = 1'b1;
        end else if (c.action == rge_pkg::ACT_ADD_LINK || c.action == rge_pkg::ACT_QUERY) begin
            if (!shadow_pages[a]) begin
                o.status = rge_pkg::ST_FIRST_MISSING;
            end else if (!shadow_pages[b]) begin
                o.status = rge_pkg::ST_SECOND_MISSING;
            end else if (c.action == rge_pkg::ACT_ADD_LINK) begin
                shadow_links[a][b] = 1'b1;
            end else begin
                o.reachable = walk_reaches(a, b);
                if (o.reachable) reached_count++;
                else unreached_count++;
            end
        end
        if (o.status != rge_pkg::ST_OK) begin
            shadow_sticky = 1'b1;
            error_count++;
        end
        o.error_seen = shadow_sticky;
        return o;
    endfunction

    // drive one command, record its result on acceptance, then maybe pause
    task automatic send_command(t_command c);
        int gap;
        s_axis_tdata <= {2'b00, c};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(apply_command(c));
        sent_count++;
        gap = 0;
        if (tx_gaps_on && $urandom_range(0, 99) < 45) gap = gap_length();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_fields(logic [1:0] act, int first, int second);
        t_command c;
        c.action = act;
        c.first_page = first[PAGE_W-1:0];
        c.second_page = second[PAGE_W-1:0];
        send_command(c);
    endtask

    // a page that exists, if one is found within a few tries
    function automatic int pick_present_page();
        int p;
        for (int t = 0; t < 8; t++) begin
            p = $urandom_range(0, PAGES - 1);
            if (shadow_pages[p]) return p;
        end
        return p;
    endfunction

    // mostly well formed graph building and queries, forward links give long paths
    function automatic t_command make_graph_command(int add_weight);
        t_command c;
        int r;
        int src;
        int dst;
        r = $urandom_range(0, 99);
        if (r < add_weight) begin
            c.action = rge_pkg::ACT_ADD_PAGE;
            c.first_page = PAGE_W'($urandom_range(0, PAGES - 1));
            c.second_page = PAGE_W'($urandom_range(0, PAGES - 1));
        end else if (r < add_weight + 38) begin
            c.action = rge_pkg::ACT_ADD_LINK;
            if ($urandom_range(0, 99) < 10) begin
                src = $urandom_range(0, PAGES - 1);
                dst = $urandom_range(0, PAGES - 1);
            end else begin
                src = pick_present_page();
                dst = src + $urandom_range(1, 4);
                if (dst >= PAGES || $urandom_range(0, 99) < 4) dst = pick_present_page();
            end
            c.first_page = PAGE_W'(src);
            c.second_page = PAGE_W'(dst);
        end else if (r < 95) begin
            c.action = rge_pkg::ACT_QUERY;
            src = pick_present_page();
            if ($urandom_range(0, 1)) begin
                dst = src + $urandom_range(0, 40);
                if (dst >= PAGES) dst = PAGES - 1;
            end else begin
                dst = pick_present_page();
            end
            c.first_page = PAGE_W'(src);
            c.second_page = PAGE_W'(dst);
        end else begin
            c.action = ACT_UNUSED;
            c.first_page = PAGE_W'($urandom_range(0, PAGES - 1));
            c.second_page = PAGE_W'($urandom_range(0, PAGES - 1));
        end
        return c;
    endfunction

    // result receiver with random back pressure
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (rx_stalls_on && $urandom_range(0, 99) < 25) begin
                m_axis_tready <= 1'b0;
                hold = gap_length();
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // compare each result transaction with the oldest expected result
    initial begin
        t_outcome want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result with nothing expected, actual tdata %h",
                             $time, m_axis_tdata);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    checked_count++;
                    if (m_axis_tdata[1:0] !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_axis_tdata[1:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[2] !== want.reachable) begin
                        $display("%0t: reachable expected %0b actual %0b",
                                 $time, want.reachable, m_axis_tdata[2]);
                        fail_count++;
                    end
                    if (m_axis_tdata[3] !== want.error_seen) begin
                        $display("%0t: error_seen expected %0b actual %0b",
                                 $time, want.error_seen, m_axis_tdata[3]);
                        fail_count++;
                    end
                end
            end
        end
    end

    // first pages, links and queries before any error
    task automatic test_clean_graph();
        tx_gaps_on = 1'b0;
        rx_stalls_on = 1'b0;
        send_fields(rge_pkg::ACT_ADD_PAGE, 0, 0);
        send_fields(rge_pkg::ACT_ADD_PAGE, 63, 0);
        send_fields(ACT_UNUSED, 0, 63);
        send_fields(rge_pkg::ACT_ADD_LINK, 0, 63);
        send_fields(rge_pkg::ACT_QUERY, 0, 0);
        send_fields(rge_pkg::ACT_QUERY, 0, 63);
        send_fields(rge_pkg::ACT_QUERY, 63, 0);
        // link that already exists
        send_fields(rge_pkg::ACT_ADD_LINK, 0, 63);
    endtask

    // duplicate page and missing pages on links and queries
    task automatic test_error_cases();
        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
        send_fields(rge_pkg::ACT_ADD_PAGE, 0, 63);
        send_fields(rge_pkg::ACT_ADD_LINK, 5, 0);
        send_fields(rge_pkg::ACT_ADD_LINK, 0, 5);
        send_fields(rge_pkg::ACT_QUERY, 5, 0);
        send_fields(rge_pkg::ACT_QUERY, 0, 5);
        send_fields(rge_pkg::ACT_QUERY, 5, 9);
        send_fields(rge_pkg::ACT_ADD_LINK, 9, 9);
    endtask

    // two hop paths, self loop and all-ones fields
    task automatic test_paths();
        send_fields(rge_pkg::ACT_ADD_PAGE, 5, 63);
        send_fields(rge_pkg::ACT_ADD_LINK, 63, 5);
        send_fields(rge_pkg::ACT_QUERY, 0, 5);
        send_fields(rge_pkg::ACT_QUERY, 5, 5);
        send_fields(rge_pkg::ACT_ADD_LINK, 5, 5);
        send_fields(rge_pkg::ACT_QUERY, 5, 63);
        send_fields(ACT_UNUSED, 63, 63);
        send_fields(rge_pkg::ACT_ADD_PAGE, 42, 21);
    endtask

    task automatic test_random_graph(int count, int add_weight, bit gaps, bit stalls);
        tx_gaps_on = gaps;
        rx_stalls_on = stalls;
        repeat (count) send_command(make_graph_command(add_weight));
    endtask

    // any action on any pages
    task automatic test_random_noise(int count);
        t_command c;
        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
        repeat (count) begin
            c.action = 2'($urandom_range(0, 3));
            c.first_page = PAGE_W'($urandom_range(0, PAGES - 1));
            c.second_page = PAGE_W'($urandom_range(0, PAGES - 1));
            send_command(c);
        end
    endtask

    // main sequence
    initial begin
        shadow_pages = '0;
        for (int i = 0; i < PAGES; i++) shadow_links[i] = '0;
        shadow_sticky = 1'b0;
        fail_count = 0;
        sent_count = 0;
        checked_count = 0;
        reached_count = 0;
        unreached_count = 0;
        error_count = 0;
        deepest_walk = 0;
        tx_gaps_on = 1'b0;
        rx_stalls_on = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_clean_graph();
        test_error_cases();
        test_paths();
        test_random_graph(200, 40, 1'b0, 1'b0);
        test_random_graph(350, 12, 1'b1, 1'b1);
        test_random_graph(250, 12, 1'b1, 1'b0);
        test_random_graph(250, 12, 1'b0, 1'b1);
        test_random_noise(180);
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d commands, checked %0d results, %0d with an error status",
                 sent_count, checked_count, error_count);
        $display("queries: %0d reachable, %0d not reachable, longest walk %0d rounds",
                 reached_count, unreached_count, deepest_walk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
